[rtl/core/tpcm_pkg.sv]
// package for the terminal palette colour mapper: types, tables and constants
`default_nettype none

package tpcm_pkg;

    localparam int IDX_W      = 4;
    localparam int THEME_W    = 4;
    localparam int RGB_W      = 24;
    localparam int CH_W       = 8;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // signed product (fg - bg) * pct and its magnitude
    localparam int PROD_W     = 17;
    localparam int MAG_W      = 15;

    // divide by 100 as multiply by 5243 then shift right by 19
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int QPROD_W     = MAG_W + RECIP_W;

    // theme numbers
    localparam logic [THEME_W-1:0] THEME_FULL_COLOUR = 4'd0;
    localparam logic [THEME_W-1:0] THEME_AMBER       = 4'd1;
    localparam logic [THEME_W-1:0] THEME_CUSTOM      = 4'd11;
    localparam logic [THEME_W-1:0] THEME_COUNT       = 4'd12;

    // register reset values
    localparam logic [THEME_W-1:0] THEME_RESET  = THEME_AMBER;
    localparam logic [RGB_W-1:0]   CUSTOM_FG_RESET = 24'hFFFFFF;
    localparam logic [RGB_W-1:0]   CUSTOM_BG_RESET = 24'h000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THEME_SELECT = 2'd0,
        CFG_CUSTOM_FG    = 2'd1,
        CFG_CUSTOM_BG    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [RGB_W-1:0] fg;
        logic [RGB_W-1:0] bg;
        logic             full_colour;
        logic             dim;
    } theme_row_t;

    // fixed theme rows; custom row carries placeholders overridden by registers
    function automatic theme_row_t theme_row(input logic [THEME_W-1:0] t);
        theme_row_t r;
        r = '{fg: 24'hFFB000, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
        unique case (t)
            4'd0:    r = '{fg: 24'h000000, bg: 24'h000000, full_colour: 1'b1, dim: 1'b0};
            4'd1:    r = '{fg: 24'hFFB000, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd2:    r = '{fg: 24'h33FF33, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd3:    r = '{fg: 24'hFFFFFF, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd4:    r = '{fg: 24'h66AAFF, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd5:    r = '{fg: 24'hFF3333, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd6:    r = '{fg: 24'hFFEE33, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
            4'd7:    r = '{fg: 24'hC0B6FF, bg: 24'h352879, full_colour: 1'b0, dim: 1'b0};
            4'd8:    r = '{fg: 24'h2B2FB0, bg: 24'hFFFFFF, full_colour: 1'b0, dim: 1'b0};
            4'd9:    r = '{fg: 24'h8BE870, bg: 24'h000000, full_colour: 1'b0, dim: 1'b0};
            4'd10:   r = '{fg: 24'hFFFF54, bg: 24'h0000A8, full_colour: 1'b0, dim: 1'b0};
            4'd11:   r = '{fg: 24'hFFFFFF, bg: 24'h000000, full_colour: 1'b0, dim: 1'b0};
            default: r = '{fg: 24'hFFB000, bg: 24'h000000, full_colour: 1'b0, dim: 1'b1};
        endcase
        return r;
    endfunction

    // 16-entry ansi palette
    function automatic logic [RGB_W-1:0] ansi_colour(input logic [IDX_W-1:0] idx);
        logic [RGB_W-1:0] c;
        c = 24'h000000;
        unique case (idx)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'haa0000;
            4'd2:  c = 24'h00aa00;
            4'd3:  c = 24'haa5500;
            4'd4:  c = 24'h0000aa;
            4'd5:  c = 24'haa00aa;
            4'd6:  c = 24'h00aaaa;
            4'd7:  c = 24'haaaaaa;
            4'd8:  c = 24'h555555;
            4'd9:  c = 24'hff5555;
            4'd10: c = 24'h55ff55;
            4'd11: c = 24'hffff55;
            4'd12: c = 24'h5555ff;
            4'd13: c = 24'hff55ff;
            4'd14: c = 24'h55ffff;
            4'd15: c = 24'hffffff;
        endcase
        return c;
    endfunction

    // brightness percent from the dim or full curve
    function automatic logic [PCT_W-1:0] curve_pct(input logic dim,
                                                   input logic [IDX_W-1:0] idx);
        logic [PCT_W-1:0] p;
        p = 7'd100;
        unique case (idx)
            4'd0:                          p = 7'd0;
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
            4'd6:                          p = dim ? 7'd55 : 7'd60;
            4'd7:                          p = dim ? 7'd70 : 7'd100;
            4'd8:                          p = dim ? 7'd40 : 7'd50;
            default:                       p = 7'd100;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tpcm_if.sv]
// stream interfaces for the colour index input and the pixel output
`default_nettype none

interface tpcm_in_if;
    logic                         valid;
    logic                         ready;
    logic [tpcm_pkg::IDX_W-1:0]   colour_index;

    modport source (output valid, output colour_index, input ready);
    modport sink   (input valid, input colour_index, output ready);
endinterface

interface tpcm_out_if;
    logic                         valid;
    logic                         ready;
    logic [tpcm_pkg::RGB_W-1:0]   pixel_rgb;

    modport source (output valid, output pixel_rgb, input ready);
    modport sink   (input valid, input pixel_rgb, output ready);
endinterface

`default_nettype wire

[rtl/core/terminal_palette_colour_mapper.sv]
// Terminal palette colour mapper.
//
// in_ch carries one 4-bit ansi colour index per beat, out_ch one 24-bit
// pixel (0xRRGGBB) per beat, in the same order. Both are valid/ready
// streams; a beat moves when valid and ready are both high.
// The cfg port writes theme_select (index 0), custom_foreground (1) and
// custom_background (2) whenever cfg_we is high; other indexes are ignored.
// Write it only while no beat is in flight.
// Throughput is one beat per cycle while out_ch is ready. The path is
// three registered stages: the index register, the (fg - bg) * pct
// product register, and the divide-by-100 result register (reciprocal
// multiply).
// When out_ch stalls, each stage holds its beat; empty stages ahead of a
// stalled one keep filling, so in_ch drops ready only once all three
// stages are full.
// Reset clears all stage valids and loads theme 1 (amber) with custom
// white on black.
`default_nettype none

module terminal_palette_colour_mapper (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tpcm_in_if.sink                                in_ch,
    tpcm_out_if.source                             out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [tpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // config registers
    logic [tpcm_pkg::THEME_W-1:0] theme_reg;
    logic [tpcm_pkg::RGB_W-1:0]   custom_fg_reg;
    logic [tpcm_pkg::RGB_W-1:0]   custom_bg_reg;

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_en, s2_en, s3_en;

    // stage payloads
    logic [tpcm_pkg::IDX_W-1:0]                  s1_idx_reg;
    logic                                        s2_full_reg;
    logic [tpcm_pkg::RGB_W-1:0]                  s2_ansi_reg;
    logic [2:0][tpcm_pkg::CH_W-1:0]              s2_bg_reg;
    logic signed [2:0][tpcm_pkg::PROD_W-1:0]     s2_prod_reg;
    logic [tpcm_pkg::RGB_W-1:0]                  pixel_reg;

    logic [tpcm_pkg::THEME_W-1:0]                theme_eff;
    tpcm_pkg::theme_row_t                        row;
    logic [tpcm_pkg::RGB_W-1:0]                  fg_sel, bg_sel;
    logic [tpcm_pkg::PCT_W-1:0]                  pct;
    logic [2:0][tpcm_pkg::CH_W-1:0]              bg_next;
    logic signed [2:0][tpcm_pkg::PROD_W-1:0]     prod_next;
    logic [tpcm_pkg::RGB_W-1:0]                  pixel_next;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theme_reg     <= tpcm_pkg::THEME_RESET;
            custom_fg_reg <= tpcm_pkg::CUSTOM_FG_RESET;
            custom_bg_reg <= tpcm_pkg::CUSTOM_BG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tpcm_pkg::CFG_THEME_SELECT)
                theme_reg <= cfg_data[tpcm_pkg::THEME_W-1:0];
            else if (cfg_index == tpcm_pkg::CFG_CUSTOM_FG)
                custom_fg_reg <= cfg_data[tpcm_pkg::RGB_W-1:0];
            else if (cfg_index == tpcm_pkg::CFG_CUSTOM_BG)
                custom_bg_reg <= cfg_data[tpcm_pkg::RGB_W-1:0];
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    assign s3_en       = !s3_valid_reg || out_ch.ready;
    assign s2_en       = !s2_valid_reg || s3_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign in_ch.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_ch.valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: capture index
    always_ff @(posedge clk)
    begin
        if (s1_en && in_ch.valid)
            s1_idx_reg <= in_ch.colour_index;
    end

    // theme decode with fallback for out-of-range numbers
    always_comb
    begin
        theme_eff = (theme_reg >= tpcm_pkg::THEME_COUNT) ? tpcm_pkg::THEME_AMBER : theme_reg;
        row       = tpcm_pkg::theme_row(theme_eff);
        fg_sel    = (theme_eff == tpcm_pkg::THEME_CUSTOM) ? custom_fg_reg : row.fg;
        bg_sel    = (theme_eff == tpcm_pkg::THEME_CUSTOM) ? custom_bg_reg : row.bg;
        pct       = tpcm_pkg::curve_pct(row.dim, s1_idx_reg);
    end

    // per-channel signed (fg - bg) * pct
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [tpcm_pkg::CH_W:0] diff;
            diff = $signed({1'b0, fg_sel[c*tpcm_pkg::CH_W +: tpcm_pkg::CH_W]})
                 - $signed({1'b0, bg_sel[c*tpcm_pkg::CH_W +: tpcm_pkg::CH_W]});
            bg_next[c]   = bg_sel[c*tpcm_pkg::CH_W +: tpcm_pkg::CH_W];
            prod_next[c] = tpcm_pkg::PROD_W'(diff * $signed({1'b0, pct}));
        end
    end

    // stage 2: product register
    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_full_reg <= row.full_colour;
            s2_ansi_reg <= tpcm_pkg::ansi_colour(s1_idx_reg);
            s2_bg_reg   <= bg_next;
            s2_prod_reg <= prod_next;
        end
    end

    // divide by 100 toward zero on the magnitude, add to bg (ansi if full)
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [tpcm_pkg::PROD_W-1:0]  neg_prod;
            logic [tpcm_pkg::MAG_W-1:0]   mag;
            logic [tpcm_pkg::QPROD_W-1:0] qprod;
            logic [tpcm_pkg::CH_W-1:0]    quot;
            logic [tpcm_pkg::CH_W-1:0]    delta;
            neg_prod = -s2_prod_reg[c];
            mag      = s2_prod_reg[c][tpcm_pkg::PROD_W-1]
                       ? neg_prod[tpcm_pkg::MAG_W-1:0]
                       : s2_prod_reg[c][tpcm_pkg::MAG_W-1:0];
            qprod    = tpcm_pkg::QPROD_W'(mag) * tpcm_pkg::QPROD_W'(tpcm_pkg::RECIP_100);
            quot     = qprod[tpcm_pkg::RECIP_SHIFT +: tpcm_pkg::CH_W];
            delta    = s2_prod_reg[c][tpcm_pkg::PROD_W-1] ? (~quot + 8'd1) : quot;
            pixel_next[c*tpcm_pkg::CH_W +: tpcm_pkg::CH_W] = s2_bg_reg[c] + delta;
        end
        if (s2_full_reg)
            pixel_next = s2_ansi_reg;
    end

    // stage 3: result register
    always_ff @(posedge clk)
    begin
        if (s3_en && s2_valid_reg)
            pixel_reg <= pixel_next;
    end

    assign out_ch.valid     = s3_valid_reg;
    assign out_ch.pixel_rgb = pixel_reg;

`ifndef SYNTHESIS
    // an accepted beat always lands in the index register
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> s1_valid_reg)
        else $error("accepted beat not captured");

    // input is blocked only when every stage holds a beat behind a stall
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && !out_ch.ready)
        else $error("input blocked with room in pipeline");

    // a new output beat comes from a full product stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s3_valid_reg) |-> $past(s2_valid_reg))
        else $error("output valid without product stage");
`endif

endmodule

`default_nettype wire
